// File: rtl/round_robin_ready_list_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef ROUND_ROBIN_READY_LIST_UNIT_MACROS_SVH
`define ROUND_ROBIN_READY_LIST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk and silent during reset.
`define RRRL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and silent during reset.
`define RRRL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rrrl_pkg.sv
`timescale 1ns / 1ps

package rrrl_pkg;

    localparam int unsigned ID_W     = 6;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned COUNT_W  = 7;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READY  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SLEEP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOT = 2'd2;

    // Context switch kinds.
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_SAVE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   task_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     new_id;
        logic [ID_W-1:0]     previous_task;
        logic [ID_W-1:0]     current_task;
        logic [KIND_W-1:0]   switch_kind;
        logic [COUNT_W-1:0]  ready_count;
    } rsp_t;

    typedef struct packed {
        logic take_in;
        logic prev_rd;
        logic prev_cap;
        logic alloc_step;
        logic scan_step;
        logic remove;
        logic cur_rd;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic go_alloc;
        logic go_scan;
        logic alloc_done;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/rrrl_ram.sv
`timescale 1ns / 1ps

module rrrl_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: rtl/rrrl_ctrl.sv
`timescale 1ns / 1ps

module rrrl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rrrl_pkg::dp_stat_t stat,
    output rrrl_pkg::dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_PREV    = 8'b0000_0010,
        ST_PREVCAP = 8'b0000_0100,
        ST_ALLOC   = 8'b0000_1000,
        ST_SCAN    = 8'b0001_0000,
        ST_REMOVE  = 8'b0010_0000,
        ST_CUR     = 8'b0100_0000,
        ST_CURCAP  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_PREV;
                end
            end
            ST_PREV: begin
                cmd.prev_rd = 1'b1;
                state_next  = ST_PREVCAP;
            end
            ST_PREVCAP: begin
                cmd.prev_cap = 1'b1;
                priority if (stat.go_alloc) begin
                    state_next = ST_ALLOC;
                end else if (stat.go_scan) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_CUR;
                end
            end
            ST_ALLOC: begin
                cmd.alloc_step = 1'b1;
                if (stat.alloc_done) begin
                    state_next = ST_CUR;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = ST_CUR;
            end
            ST_CUR: begin
                cmd.cur_rd = 1'b1;
                state_next = ST_CURCAP;
            end
            ST_CURCAP: begin
                // The read data of the list RAM holds until the result register is free.
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rrrl_dpath.sv
`timescale 1ns / 1ps

module rrrl_dpath #(
    parameter int unsigned TASK_SLOTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rrrl_pkg::req_t     s_data,
    input  rrrl_pkg::dp_cmd_t  cmd,
    output rrrl_pkg::dp_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output rrrl_pkg::rsp_t     m_data
);

    localparam int unsigned IW = $clog2(TASK_SLOTS);
    localparam int unsigned TW = $clog2(TASK_SLOTS + 1);

    rrrl_pkg::req_t                    req_reg, req_next;
    logic [TASK_SLOTS-1:0]             used_reg, used_next;
    logic [TASK_SLOTS-1:0]             ready_reg, ready_next;
    logic [TW-1:0]                     total_reg, total_next;
    logic [IW-1:0]                     cur_reg, cur_next;
    logic [TW-1:0]                     cnt_reg, cnt_next;
    logic                              pend_reg, pend_next;
    logic [IW-1:0]                     addr_q_reg, addr_q_next;
    logic                              found_reg, found_next;
    logic [IW-1:0]                     pos_reg, pos_next;
    logic [rrrl_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [rrrl_pkg::ID_W-1:0]         new_id_reg, new_id_next;
    logic [rrrl_pkg::ID_W-1:0]         prev_reg, prev_next;
    logic [rrrl_pkg::KIND_W-1:0]       kind_reg, kind_next;
    rrrl_pkg::rsp_t                    out_reg, out_next;
    logic                              m_valid_reg, m_valid_next;

    logic                              id_ok;
    logic [IW-1:0]                     id_idx;
    logic [IW-1:0]                     cnt_idx;
    logic                              id_ready;
    logic                              ready_ok;
    logic                              remove_ok;
    logic                              is_remove;
    logic                              alloc_free;
    logic [TW-1:0]                     cur_ext;
    logic [TW-1:0]                     cur_inc;
    logic [TW-1:0]                     new_total;
    logic [rrrl_pkg::ID_W-1:0]         running;
    logic                              scan_issue;
    logic                              scan_move;

    logic                              ram_wr_en;
    logic [IW-1:0]                     ram_wr_addr;
    logic [rrrl_pkg::ID_W-1:0]         ram_wr_data;
    logic                              ram_rd_en;
    logic [IW-1:0]                     ram_rd_addr;
    logic [rrrl_pkg::ID_W-1:0]         ram_rd_data;

    assign id_ok      = int'(req_reg.task_id) < TASK_SLOTS;
    assign id_idx     = IW'(req_reg.task_id);
    assign cnt_idx    = cnt_reg[IW-1:0];
    assign id_ready   = id_ok && ready_reg[id_idx];
    assign ready_ok   = id_ok && !id_ready && (total_reg != TW'(TASK_SLOTS));
    assign remove_ok  = id_ready;
    assign is_remove  = (req_reg.func == rrrl_pkg::FUNC_SLEEP) ||
                        (req_reg.func == rrrl_pkg::FUNC_DELETE);
    assign alloc_free = !used_reg[cnt_idx];
    assign cur_ext    = TW'(cur_reg);
    assign cur_inc    = cur_ext + TW'(1);
    assign new_total  = total_reg - TW'(1);

    // Task at the current index, or zero when the list is empty.
    assign running = ((total_reg == '0) || (cur_ext >= total_reg)) ? '0 : ram_rd_data;

    // The removal pass reads entry i while moving entry i-1 into slot i-2 once the target is found.
    assign scan_issue = cmd.scan_step && (cnt_reg < total_reg);
    assign scan_move  = cmd.scan_step && pend_reg && found_reg;

    assign ram_rd_en   = cmd.prev_rd || cmd.cur_rd || scan_issue;
    assign ram_rd_addr = scan_issue ? cnt_idx : cur_reg;
    assign ram_wr_en   = scan_move ||
                         (cmd.prev_cap && (req_reg.func == rrrl_pkg::FUNC_READY) && ready_ok);
    assign ram_wr_addr = scan_move ? (addr_q_reg - IW'(1)) : total_reg[IW-1:0];
    assign ram_wr_data = scan_move ? ram_rd_data : req_reg.task_id;

    rrrl_ram #(
        .WIDTH (rrrl_pkg::ID_W),
        .DEPTH (TASK_SLOTS)
    ) u_list_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign stat.go_alloc   = (req_reg.func == rrrl_pkg::FUNC_ALLOC);
    assign stat.go_scan    = is_remove && remove_ok;
    assign stat.alloc_done = alloc_free || (cnt_reg == TW'(TASK_SLOTS - 1));
    assign stat.scan_done  = !pend_reg && (cnt_reg >= total_reg);
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        req_next     = req_reg;
        used_next    = used_reg;
        ready_next   = ready_reg;
        total_next   = total_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        addr_q_next  = addr_q_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        status_next  = status_reg;
        new_id_next  = new_id_reg;
        prev_next    = prev_reg;
        kind_next    = kind_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (cmd.take_in) begin
            req_next = s_data;
        end

        if (cmd.prev_cap) begin
            prev_next   = running;
            status_next = rrrl_pkg::STATUS_DONE;
            new_id_next = '0;
            kind_next   = rrrl_pkg::KIND_NONE;
            cnt_next    = '0;
            pend_next   = 1'b0;
            found_next  = 1'b0;
            unique case (req_reg.func)
                rrrl_pkg::FUNC_ALLOC: begin
                    status_next = rrrl_pkg::STATUS_NO_SLOT;
                end
                rrrl_pkg::FUNC_READY: begin
                    if (ready_ok) begin
                        used_next[id_idx]  = 1'b1;
                        ready_next[id_idx] = 1'b1;
                        total_next         = total_reg + TW'(1);
                    end else begin
                        status_next = rrrl_pkg::STATUS_IGNORED;
                    end
                end
                rrrl_pkg::FUNC_SLEEP, rrrl_pkg::FUNC_DELETE: begin
                    if (remove_ok) begin
                        ready_next[id_idx] = 1'b0;
                        used_next[id_idx]  = (req_reg.func == rrrl_pkg::FUNC_SLEEP);
                    end else begin
                        status_next = rrrl_pkg::STATUS_IGNORED;
                    end
                end
                rrrl_pkg::FUNC_TICK: begin
                    if (total_reg > TW'(1)) begin
                        cur_next  = (cur_inc >= total_reg) ? '0 : cur_inc[IW-1:0];
                        kind_next = rrrl_pkg::KIND_SAVE;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.alloc_step) begin
            if (alloc_free) begin
                used_next[cnt_idx] = 1'b1;
                new_id_next        = 6'(cnt_reg);
                status_next        = rrrl_pkg::STATUS_DONE;
            end else begin
                cnt_next = cnt_reg + TW'(1);
            end
        end

        if (cmd.scan_step) begin
            if (pend_reg && !found_reg && (ram_rd_data == req_reg.task_id)) begin
                found_next = 1'b1;
                pos_next   = addr_q_reg;
            end
            if (scan_issue) begin
                cnt_next    = cnt_reg + TW'(1);
                addr_q_next = cnt_idx;
                pend_next   = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
        end

        if (cmd.remove && found_reg) begin
            total_next = new_total;
            if (cur_reg > pos_reg) begin
                cur_next = cur_reg - IW'(1);
            end else if (cur_reg == pos_reg) begin
                // The entry that slid into place becomes current.
                if (cur_ext >= new_total) begin
                    cur_next = '0;
                end
                if (new_total != '0) begin
                    kind_next = (req_reg.func == rrrl_pkg::FUNC_SLEEP) ?
                                rrrl_pkg::KIND_SAVE : rrrl_pkg::KIND_NO_SAVE;
                end
            end
        end

        if (cmd.out_load) begin
            out_next.status        = status_reg;
            out_next.new_id        = new_id_reg;
            out_next.previous_task = prev_reg;
            out_next.current_task  = running;
            out_next.switch_kind   = kind_reg;
            out_next.ready_count   = 7'(total_reg);
            m_valid_next           = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            ready_reg   <= '0;
            total_reg   <= '0;
            cur_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            ready_reg   <= ready_next;
            total_reg   <= total_next;
            cur_reg     <= cur_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        cnt_reg    <= cnt_next;
        addr_q_reg <= addr_q_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        new_id_reg <= new_id_next;
        prev_reg   <= prev_next;
        kind_reg   <= kind_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/round_robin_ready_list_unit.sv
`timescale 1ns / 1ps

// Round-robin ready list: keeps the free/created/ready state of TASK_SLOTS task slots in
// flip-flops cleared by reset, and the ordered ready list in a single-port-per-side RAM,
// so no clearing pass is needed after reset. One request is handled at a time; s_ready is
// high only while the unit is idle, and a finished result waits in the output register
// while the next request is taken. A make-ready, tick, unknown or ignored request passes
// through the previous-task read and capture, the current-task read and the result load.
// An allocate adds a search of up to TASK_SLOTS slots, one slot a cycle. A sleep or
// delete adds a pass over the ready list: the list RAM is searched and compacted in one
// pass, one entry per cycle, reading entry i while moving entry i-1 into slot i-2.
module round_robin_ready_list_unit #(
    parameter int unsigned TASK_SLOTS = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rrrl_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rrrl_pkg::rsp_t m_data
);

    rrrl_pkg::dp_cmd_t  cmd;
    rrrl_pkg::dp_stat_t stat;

    rrrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrrl_dpath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/rrrl_checker.sv
`timescale 1ns / 1ps

`include "round_robin_ready_list_unit_macros.svh"

module rrrl_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input rrrl_pkg::rsp_t m_data
);

    `RRRL_ASSERT_NXT(a_result_held, m_valid && !m_ready, m_valid,
        "result valid dropped before its transfer")

    `RRRL_ASSERT_NXT(a_result_stable, m_valid && !m_ready, $stable(m_data),
        "result payload changed while stalled")

    // Only one request is in the unit at a time.
    `RRRL_ASSERT_NXT(a_one_request, s_valid && s_ready, !s_ready,
        "request taken while another one is in progress")

    `RRRL_ASSERT_IMP(a_result_after_work, $rose(m_valid), $past(!s_ready),
        "result appeared without a request in progress")

    `RRRL_ASSERT_IMP(a_switch_has_task,
        m_valid && (m_data.switch_kind != rrrl_pkg::KIND_NONE),
        m_data.ready_count != 7'd0,
        "context switch reported with an empty ready list")

endmodule

bind round_robin_ready_list_unit rrrl_checker u_rrrl_checker (.*);

// File: test/tb_round_robin_ready_list_unit.sv
`timescale 1ns / 1ps

module tb_round_robin_ready_list_unit;

    localparam int unsigned TASK_SLOTS = 64;

    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_CREATED = 2'd1;
    localparam logic [1:0] SLOT_READY   = 2'd2;

    // Codes 5 to 7 have no meaning and must leave everything untouched.
    localparam logic [rrrl_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd5;
    localparam logic [rrrl_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd6;
    localparam logic [rrrl_pkg::FUNC_W-1:0] FUNC_SPARE_C = 3'd7;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    rrrl_pkg::req_t s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    rrrl_pkg::rsp_t m_data;

    // Scheduler state as the testbench sees it.
    logic [1:0]                slot_state [TASK_SLOTS];
    logic [rrrl_pkg::ID_W-1:0] ready_list [TASK_SLOTS];
    int unsigned               list_len;
    int unsigned               run_index;

    rrrl_pkg::rsp_t sched_replies_due[$];

    bit          idle_enable = 1'b1;
    int unsigned hold_cycles_req = 0;
    int unsigned hold_left = 0;

    int unsigned error_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned replies_seen  = 0;
    int unsigned switch_count  = 0;
    int unsigned no_slot_count = 0;
    int unsigned ignored_count = 0;

    round_robin_ready_list_unit #(
        .TASK_SLOTS(TASK_SLOTS)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [rrrl_pkg::ID_W-1:0] running_task();
        if (list_len == 0 || run_index >= list_len)
            return '0;
        return ready_list[run_index];
    endfunction

    // Applies one request to the local scheduler state and returns the reply it should cause.
    function automatic rrrl_pkg::rsp_t apply_sched_request(input rrrl_pkg::req_t req);
        rrrl_pkg::rsp_t rsp;
        int unsigned    pos;
        rsp = '0;
        rsp.status = rrrl_pkg::STATUS_DONE;
        rsp.switch_kind = rrrl_pkg::KIND_NONE;
        rsp.previous_task = running_task();
        case (req.func)
            rrrl_pkg::FUNC_ALLOC: begin
                rsp.status = rrrl_pkg::STATUS_NO_SLOT;
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (slot_state[i] == SLOT_FREE) begin
                        slot_state[i] = SLOT_CREATED;
                        rsp.new_id = rrrl_pkg::ID_W'(i);
                        rsp.status = rrrl_pkg::STATUS_DONE;
                        break;
                    end
                end
            end
            rrrl_pkg::FUNC_READY: begin
                if (slot_state[req.task_id] == SLOT_READY || list_len >= TASK_SLOTS) begin
                    rsp.status = rrrl_pkg::STATUS_IGNORED;
                end else begin
                    slot_state[req.task_id] = SLOT_READY;
                    ready_list[list_len] = req.task_id;
                    list_len++;
                end
            end
            rrrl_pkg::FUNC_SLEEP, rrrl_pkg::FUNC_DELETE: begin
                if (slot_state[req.task_id] != SLOT_READY) begin
                    rsp.status = rrrl_pkg::STATUS_IGNORED;
                end else begin
                    slot_state[req.task_id] = (req.func == rrrl_pkg::FUNC_SLEEP) ?
                                              SLOT_CREATED : SLOT_FREE;
                    pos = list_len;
                    for (int i = 0; i < list_len; i++) begin
                        if (ready_list[i] == req.task_id) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < list_len) begin
                        for (int i = pos; i + 1 < list_len; i++)
                            ready_list[i] = ready_list[i + 1];
                        list_len--;
                        if (run_index > pos) begin
                            run_index--;
                        end else if (run_index == pos) begin
                            // The entry that slid into place becomes current.
                            if (run_index >= list_len)
                                run_index = 0;
                            if (list_len > 0)
                                rsp.switch_kind = (req.func == rrrl_pkg::FUNC_SLEEP) ?
                                                  rrrl_pkg::KIND_SAVE :
                                                  rrrl_pkg::KIND_NO_SAVE;
                        end
                    end
                end
            end
            rrrl_pkg::FUNC_TICK: begin
                if (list_len > 1) begin
                    run_index++;
                    if (run_index >= list_len)
                        run_index = 0;
                    rsp.switch_kind = rrrl_pkg::KIND_SAVE;
                end
            end
            default: begin
            end
        endcase
        rsp.current_task = running_task();
        rsp.ready_count = rrrl_pkg::COUNT_W'(list_len);
        return rsp;
    endfunction

    task automatic send_request(input logic [rrrl_pkg::FUNC_W-1:0] func,
                                input logic [rrrl_pkg::ID_W-1:0] id);
        rrrl_pkg::req_t req;
        req.func = func;
        req.task_id = id;
        if (idle_enable && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sched_replies_due.push_back(apply_sched_request(req));
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sched_replies_due.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: counts down a requested hold, else idles at random if idle_enable is set.
    always @(posedge aclk) begin
        if (hold_cycles_req != 0) begin
            hold_left = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (idle_enable) begin
            m_ready <= ($urandom_range(99) >= 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        rrrl_pkg::rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (m_data.switch_kind != rrrl_pkg::KIND_NONE)
                switch_count++;
            if (m_data.status == rrrl_pkg::STATUS_NO_SLOT)
                no_slot_count++;
            if (m_data.status == rrrl_pkg::STATUS_IGNORED)
                ignored_count++;
            if (sched_replies_due.size() == 0) begin
                $error("reply transfer with no request outstanding: %p", m_data);
                error_count++;
            end else begin
                want = sched_replies_due.pop_front();
                check_field("status", 8'(want.status), 8'(m_data.status));
                check_field("new_id", 8'(want.new_id), 8'(m_data.new_id));
                check_field("previous_task", 8'(want.previous_task), 8'(m_data.previous_task));
                check_field("current_task", 8'(want.current_task), 8'(m_data.current_task));
                check_field("switch_kind", 8'(want.switch_kind), 8'(m_data.switch_kind));
                check_field("ready_count", 8'(want.ready_count), 8'(m_data.ready_count));
            end
        end
    end

    // Walks through each operation and the corner cases of list removal by hand.
    task automatic test_directed();
        send_request(rrrl_pkg::FUNC_TICK, '0);
        send_request(rrrl_pkg::FUNC_SLEEP, 6'd0);
        send_request(FUNC_SPARE_A, 6'd0);
        send_request(FUNC_SPARE_B, 6'd63);
        send_request(FUNC_SPARE_C, 6'd42);
        send_request(rrrl_pkg::FUNC_ALLOC, '0);
        send_request(rrrl_pkg::FUNC_READY, 6'd0);
        send_request(rrrl_pkg::FUNC_READY, 6'd63);
        send_request(rrrl_pkg::FUNC_READY, 6'd63);
        send_request(rrrl_pkg::FUNC_TICK, '0);
        send_request(rrrl_pkg::FUNC_ALLOC, 6'd63);
        send_request(rrrl_pkg::FUNC_READY, 6'd1);
        // Removing an entry ahead of the current one shifts the index down.
        send_request(rrrl_pkg::FUNC_SLEEP, 6'd0);
        send_request(rrrl_pkg::FUNC_READY, 6'd0);
        send_request(rrrl_pkg::FUNC_TICK, '0);
        send_request(rrrl_pkg::FUNC_TICK, '0);
        // Deleting the current task at the end of the list wraps to the front.
        send_request(rrrl_pkg::FUNC_DELETE, 6'd0);
        send_request(rrrl_pkg::FUNC_READY, 6'd5);
        send_request(rrrl_pkg::FUNC_SLEEP, 6'd5);
        send_request(rrrl_pkg::FUNC_SLEEP, 6'd63);
        send_request(rrrl_pkg::FUNC_DELETE, 6'd1);
        send_request(rrrl_pkg::FUNC_DELETE, 6'd1);
        send_request(rrrl_pkg::FUNC_DELETE, 6'd42);
        wait_until_drained();
    endtask

    // Claims every slot, then keeps asking after the table is full.
    task automatic test_table_full();
        for (int i = 0; i < TASK_SLOTS + 2; i++)
            send_request(rrrl_pkg::FUNC_ALLOC, rrrl_pkg::ID_W'($urandom));
        send_request(rrrl_pkg::FUNC_READY, 6'd63);
        send_request(rrrl_pkg::FUNC_DELETE, 6'd63);
        send_request(rrrl_pkg::FUNC_ALLOC, '0);
        wait_until_drained();
    endtask

    task automatic run_random_requests(input int unsigned count, input bit grow);
        int unsigned                 roll;
        logic [rrrl_pkg::FUNC_W-1:0] func;
        logic [rrrl_pkg::ID_W-1:0]   id;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < (grow ? 22 : 8))
                func = rrrl_pkg::FUNC_ALLOC;
            else if (roll < (grow ? 50 : 25))
                func = rrrl_pkg::FUNC_READY;
            else if (roll < (grow ? 60 : 45))
                func = rrrl_pkg::FUNC_SLEEP;
            else if (roll < 70)
                func = rrrl_pkg::FUNC_DELETE;
            else if (roll < 95)
                func = rrrl_pkg::FUNC_TICK;
            else
                func = rrrl_pkg::FUNC_W'(rrrl_pkg::FUNC_TICK + $urandom_range(1, 3));
            id = rrrl_pkg::ID_W'($urandom);
            // Most removals name a task that is really on the list.
            if ((func == rrrl_pkg::FUNC_SLEEP || func == rrrl_pkg::FUNC_DELETE) &&
                list_len != 0 && $urandom_range(99) < 75)
                id = ready_list[$urandom_range(list_len - 1)];
            send_request(func, id);
        end
    endtask

    // Receiver stops for a long while so the unit fills up and holds off its input.
    task automatic test_receiver_hold();
        idle_enable = 1'b0;
        hold_cycles_req = 400;
        run_random_requests(12, 1'b1);
        wait_until_drained();
        idle_enable = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        run_random_requests(200, 1'b1);
        run_random_requests(60, 1'b0);
        wait_until_drained();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 6; round++) begin
            run_random_requests(110, 1'b1);
            run_random_requests(60, 1'b0);
        end
        wait_until_drained();
    endtask

    initial begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_state[i] = SLOT_FREE;
            ready_list[i] = '0;
        end
        list_len = 0;
        run_index = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_table_full();
        test_receiver_hold();
        test_back_to_back();
        test_random_mix();

        wait_until_drained();
        repeat (2 * TASK_SLOTS + 20) @(posedge aclk);
        $display("Sent %0d requests and checked %0d replies.", requests_sent, replies_seen);
        $display("Replies with a task switch: %0d, ignored: %0d, table full: %0d.",
                 switch_count, ignored_count, no_slot_count);
        if (error_count == 0 && sched_replies_due.size() == 0)
            $display("round_robin_ready_list_unit: match");
        else
            $display("round_robin_ready_list_unit: mismatch");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d replies outstanding.", sched_replies_due.size());
        $display("round_robin_ready_list_unit: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/rrrl_pkg.sv
rtl/rrrl_ram.sv
rtl/rrrl_ctrl.sv
rtl/rrrl_dpath.sv
rtl/round_robin_ready_list_unit.sv
rtl/rrrl_checker.sv
test/tb_round_robin_ready_list_unit.sv
